// ----- rtl/core/las_pkg.sv -----
// Shared types, constants and step functions of the line angle snap pipeline.
// Used by every module in rtl/core; depends on nothing.
package las_pkg;

  localparam int CW  = 32;
  localparam int DW  = 33;
  localparam int XW  = 44;
  localparam int ZW  = 26;
  localparam int SW  = 65;
  localparam int RW  = 68;
  localparam int QW  = 34;
  localparam int MW  = 36;
  localparam int TW  = 25;
  localparam int AW  = 23;
  localparam int HW  = 13;
  localparam int NC  = 20;
  localparam int NI  = 34;
  localparam int NORM_MSB = 40;

  localparam int D45  = 2949120;
  localparam int D90  = 5898240;
  localparam int D180 = 11796480;
  localparam int D360 = 23592960;

  localparam logic [HW-1:0] THR_RESET = 13'd1280;

  typedef enum logic [1:0] {
    DIR_ZERO,
    DIR_POS,
    DIR_NEG
  } las_dir_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic                 negx;
    logic                 negy;
    logic                 swap;
    logic                 zero;
  } las_ctx_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [SW-1:0]        s;
    logic [QW-1:0]        q1;
    logic [QW-1:0]        q2;
    logic [MW-1:0]        r1;
    logic [MW-1:0]        r2;
  } las_work_t;

  typedef struct packed {
    logic [MW-1:0] rem;
    logic [QW-1:0] root;
  } las_sq_t;

  function automatic logic [21:0] atan_tab(input int i);
    logic [21:0] v;
    case (i)
      0:  v = 22'd2949120;
      1:  v = 22'd1740967;
      2:  v = 22'd919879;
      3:  v = 22'd466945;
      4:  v = 22'd234379;
      5:  v = 22'd117304;
      6:  v = 22'd58666;
      7:  v = 22'd29335;
      8:  v = 22'd14668;
      9:  v = 22'd7334;
      10: v = 22'd3667;
      11: v = 22'd1833;
      12: v = 22'd917;
      13: v = 22'd458;
      14: v = 22'd229;
      15: v = 22'd115;
      16: v = 22'd57;
      17: v = 22'd29;
      18: v = 22'd14;
      19: v = 22'd7;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  function automatic las_sq_t sqrt_step(input las_sq_t cur, input logic [1:0] pair);
    logic [MW+1:0] acc;
    logic [MW+1:0] trial;
    las_sq_t       res;
    acc   = {cur.rem, pair};
    trial = {2'b00, cur.root, 2'b01};
    if (acc >= trial) begin
      res.rem  = MW'(acc - trial);
      res.root = {cur.root[QW-2:0], 1'b1};
    end else begin
      res.rem  = acc[MW-1:0];
      res.root = {cur.root[QW-2:0], 1'b0};
    end
    return res;
  endfunction

  function automatic las_dir_t dir_x(input logic [2:0] idx);
    las_dir_t d;
    unique case (idx)
      3'd0, 3'd1, 3'd7: d = DIR_POS;
      3'd2, 3'd6:       d = DIR_ZERO;
      default:          d = DIR_NEG;
    endcase
    return d;
  endfunction

  function automatic las_dir_t dir_y(input logic [2:0] idx);
    las_dir_t d;
    unique case (idx)
      3'd1, 3'd2, 3'd3: d = DIR_POS;
      3'd0, 3'd4:       d = DIR_ZERO;
      default:          d = DIR_NEG;
    endcase
    return d;
  endfunction

  function automatic logic [CW-1:0] sat32(input logic signed [CW+3:0] v);
    logic [CW-1:0] r;
    if (!v[CW+3] && (|v[CW+2:CW-1])) begin
      r = {1'b0, {(CW-1){1'b1}}};
    end else if (v[CW+3] && !(&v[CW+2:CW-1])) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/las_front.sv -----
// Front stages: differences, magnitudes, squares, normalization shift.
// Depends on las_pkg.
module las_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [las_pkg::CW-1:0] start_x,
  input  logic signed [las_pkg::CW-1:0] start_y,
  input  logic signed [las_pkg::CW-1:0] current_x,
  input  logic signed [las_pkg::CW-1:0] current_y,
  output logic                         out_valid,
  output las_pkg::las_ctx_t            out_ctx,
  output las_pkg::las_work_t           out_work
);
  import las_pkg::*;

  logic                 v1_r, v2_r, v3_r, v4_r;
  las_ctx_t             ctx1_r, ctx2_r, ctx3_r, ctx4_r;
  las_ctx_t             ctx1_nxt, ctx2_nxt, ctx3_nxt;
  logic signed [DW-1:0] dx1_r, dy1_r;
  logic [DW-1:0]        ax_w, ay_w;
  logic [CW-1:0]        ax2_r, ay2_r, big2_r, m2_r;
  logic [2*CW-1:0]      sqx3_r, sqy3_r;
  logic [CW-1:0]        big3_r, m3_r;
  logic [5:0]           sh3_r, sh_nxt;
  las_work_t            wk4_r, wk_nxt;

  always_comb begin
    ctx1_nxt      = '0;
    ctx1_nxt.sx   = start_x;
    ctx1_nxt.sy   = start_y;
    ctx1_nxt.cx   = current_x;
    ctx1_nxt.cy   = current_y;
  end

  always_comb begin
    ax_w          = dx1_r[DW-1] ? DW'(-dx1_r) : DW'(dx1_r);
    ay_w          = dy1_r[DW-1] ? DW'(-dy1_r) : DW'(dy1_r);
    ctx2_nxt      = ctx1_r;
    ctx2_nxt.negx = dx1_r[DW-1];
    ctx2_nxt.negy = dy1_r[DW-1];
    ctx2_nxt.swap = ay_w > ax_w;
  end

  always_comb begin
    ctx3_nxt      = ctx2_r;
    ctx3_nxt.zero = (ax2_r == '0) && (ay2_r == '0);
    sh_nxt        = 6'(NORM_MSB);
    for (int i = 0; i < CW; i++) begin
      if (big2_r[i]) begin
        sh_nxt = 6'(NORM_MSB - i);
      end
    end
  end

  always_comb begin
    wk_nxt   = '0;
    wk_nxt.s = {1'b0, sqx3_r} + {1'b0, sqy3_r};
    wk_nxt.x = {{(XW-CW){1'b0}}, big3_r} << sh3_r;
    wk_nxt.y = {{(XW-CW){1'b0}}, m3_r} << sh3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx1_r <= ctx1_nxt;
      dx1_r  <= {current_x[CW-1], current_x} - {start_x[CW-1], start_x};
      dy1_r  <= {current_y[CW-1], current_y} - {start_y[CW-1], start_y};
      ctx2_r <= ctx2_nxt;
      ax2_r  <= ax_w[CW-1:0];
      ay2_r  <= ay_w[CW-1:0];
      big2_r <= ctx2_nxt.swap ? ay_w[CW-1:0] : ax_w[CW-1:0];
      m2_r   <= ctx2_nxt.swap ? ax_w[CW-1:0] : ay_w[CW-1:0];
      ctx3_r <= ctx3_nxt;
      sqx3_r <= ax2_r * ax2_r;
      sqy3_r <= ay2_r * ay2_r;
      big3_r <= big2_r;
      m3_r   <= m2_r;
      sh3_r  <= sh_nxt;
      ctx4_r <= ctx3_r;
      wk4_r  <= wk_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_ctx   = ctx4_r;
  assign out_work  = wk4_r;

endmodule

// ----- rtl/core/las_iter.sv -----
// Iteration stages: one digit of each of two square roots per stage, and
// one CORDIC rotation per stage in the first 20. Depends on las_pkg.
module las_iter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  las_pkg::las_ctx_t  in_ctx,
  input  las_pkg::las_work_t in_work,
  output logic               out_valid,
  output las_pkg::las_ctx_t  out_ctx,
  output las_pkg::las_work_t out_work
);
  import las_pkg::*;

  logic      vld_r [NI];
  las_ctx_t  ctx_r [NI];
  las_work_t wk_r  [NI];

  for (genvar j = 0; j < NI; j++) begin : g_stage
    localparam int P = NI - 1 - j;
    las_work_t cur, nxt;
    las_ctx_t  cur_ctx;
    logic      cur_v;
    logic [RW-1:0] rad1, rad2;
    las_sq_t   sq1, sq2;
    logic signed [XW-1:0] xs, ys;

    if (j == 0) begin : g_first
      assign cur     = in_work;
      assign cur_ctx = in_ctx;
      assign cur_v   = in_valid;
    end else begin : g_next
      assign cur     = wk_r[j-1];
      assign cur_ctx = ctx_r[j-1];
      assign cur_v   = vld_r[j-1];
    end

    always_comb begin
      rad1 = {2'b00, cur.s, 1'b0};
      rad2 = {1'b0, cur.s, 2'b00};
      sq1  = sqrt_step({cur.r1, cur.q1}, rad1[2*P+1 -: 2]);
      sq2  = sqrt_step({cur.r2, cur.q2}, rad2[2*P+1 -: 2]);
      xs   = cur.x >>> j;
      ys   = cur.y >>> j;
      nxt  = cur;
      nxt.r1 = sq1.rem;
      nxt.q1 = sq1.root;
      nxt.r2 = sq2.rem;
      nxt.q2 = sq2.root;
      if (j < NC) begin
        if (!cur.y[XW-1]) begin
          nxt.x = cur.x + ys;
          nxt.y = cur.y - xs;
          nxt.z = cur.z + $signed({{(ZW-22){1'b0}}, atan_tab(j)});
        end else begin
          nxt.x = cur.x - ys;
          nxt.y = cur.y + xs;
          nxt.z = cur.z - $signed({{(ZW-22){1'b0}}, atan_tab(j)});
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        wk_r[j]  <= nxt;
        ctx_r[j] <= cur_ctx;
      end
    end
  end

  assign out_valid = vld_r[NI-1];
  assign out_ctx   = ctx_r[NI-1];
  assign out_work  = wk_r[NI-1];

`ifndef ASSERT_OFF
  a_rem1_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({2'b00, out_work.r1} <= {1'b0, out_work.q1, 1'b0}))
    else $error("square root remainder exceeds twice the root (diagonal)");
  a_rem2_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({2'b00, out_work.r2} <= {1'b0, out_work.q2, 1'b0}))
    else $error("square root remainder exceeds twice the root (axis)");
  a_x_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_work.x[XW-1])
    else $error("rotated vector x went negative");
`endif

endmodule

// ----- rtl/core/las_back.sv -----
// Back stages: angle unfolding, snap direction search, end point and output register.
// Depends on las_pkg.
module las_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [las_pkg::HW-1:0]       thr,
  input  logic                         in_valid,
  input  las_pkg::las_ctx_t            in_ctx,
  input  las_pkg::las_work_t           in_work,
  output logic                         out_valid,
  output logic signed [las_pkg::CW-1:0] end_x,
  output logic signed [las_pkg::CW-1:0] end_y,
  output logic                         snapped
);
  import las_pkg::*;

  logic            vt_r, vh_r, vo_r;
  las_ctx_t        ctxt_r, ctxh_r;
  logic [QW-1:0]   q1t_r, q2t_r, q1h_r, q2h_r;
  logic [TW-1:0]   theta_r, theta_nxt;
  logic [AW-1:0]   zc, alpha;
  logic            hit_nxt, hit_r;
  logic [2:0]      idx_nxt, idx_r;
  logic signed [TW:0] diff;
  logic [TW-1:0]   gap;
  logic [QW-1:0]   lsel;
  logic [QW:0]     lrnd;
  logic [QW-1:0]   len;
  logic signed [CW+3:0] ex, ey;
  logic [CW-1:0]   endx_r, endy_r, endx_nxt, endy_nxt;
  logic            snap_r;

  always_comb begin
    if (in_work.z[ZW-1]) begin
      zc = '0;
    end else if (in_work.z > ZW'(D45)) begin
      zc = AW'(D45);
    end else begin
      zc = in_work.z[AW-1:0];
    end
    alpha = in_ctx.swap ? AW'(D90) - zc : zc;
    case ({in_ctx.negx, in_ctx.negy})
      2'b00:   theta_nxt = TW'(alpha);
      2'b10:   theta_nxt = TW'(D180) - TW'(alpha);
      2'b11:   theta_nxt = TW'(D180) + TW'(alpha);
      default: theta_nxt = (alpha == '0) ? '0 : TW'(D360) - TW'(alpha);
    endcase
    if (in_ctx.zero) begin
      theta_nxt = '0;
    end
  end

  always_comb begin
    hit_nxt = 1'b0;
    idx_nxt = '0;
    diff    = '0;
    gap     = '0;
    for (int k = 7; k >= 0; k--) begin
      diff = $signed({1'b0, theta_r}) - $signed({1'b0, TW'(k * D45)});
      gap  = diff[TW] ? TW'(-diff) : diff[TW-1:0];
      if (gap > TW'(D180)) begin
        gap = TW'(D360) - gap;
      end
      if (gap < TW'({thr, 8'd0})) begin
        hit_nxt = 1'b1;
        idx_nxt = 3'(k);
      end
    end
  end

  always_comb begin
    lsel = idx_r[0] ? q1h_r : q2h_r;
    lrnd = {1'b0, lsel} + {{QW{1'b0}}, 1'b1};
    len  = lrnd[QW:1];
    case (dir_x(idx_r))
      DIR_POS: ex = {{4{ctxh_r.sx[CW-1]}}, ctxh_r.sx} + $signed({2'b00, len});
      DIR_NEG: ex = {{4{ctxh_r.sx[CW-1]}}, ctxh_r.sx} - $signed({2'b00, len});
      default: ex = {{4{ctxh_r.sx[CW-1]}}, ctxh_r.sx};
    endcase
    case (dir_y(idx_r))
      DIR_POS: ey = {{4{ctxh_r.sy[CW-1]}}, ctxh_r.sy} + $signed({2'b00, len});
      DIR_NEG: ey = {{4{ctxh_r.sy[CW-1]}}, ctxh_r.sy} - $signed({2'b00, len});
      default: ey = {{4{ctxh_r.sy[CW-1]}}, ctxh_r.sy};
    endcase
    if (hit_r) begin
      endx_nxt = sat32(ex);
      endy_nxt = sat32(ey);
    end else begin
      endx_nxt = ctxh_r.cx;
      endy_nxt = ctxh_r.cy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
      vh_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      vt_r <= in_valid;
      vh_r <= vt_r;
      vo_r <= vh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctxt_r  <= in_ctx;
      theta_r <= theta_nxt;
      q1t_r   <= in_work.q1;
      q2t_r   <= in_work.q2;
      ctxh_r  <= ctxt_r;
      hit_r   <= hit_nxt;
      idx_r   <= idx_nxt;
      q1h_r   <= q1t_r;
      q2h_r   <= q2t_r;
      endx_r  <= endx_nxt;
      endy_r  <= endy_nxt;
      snap_r  <= hit_r;
    end
  end

  assign out_valid = vo_r;
  assign end_x     = endx_r;
  assign end_y     = endy_r;
  assign snapped   = snap_r;

`ifndef ASSERT_OFF
  a_theta_range: assert property (@(posedge clk) disable iff (!rst_n)
    vt_r |-> (theta_r < TW'(D360)))
    else $error("direction angle out of range");
  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (en && in_valid && in_ctx.zero) |=> (theta_r == '0))
    else $error("coincident points gave a nonzero direction");
`endif

endmodule

// ----- rtl/core/line_angle_snap.sv -----
// Top level of the 45 degree line angle snap pipeline with its threshold register.
// Depends on las_pkg, las_front, las_iter and las_back.
//
//  channel | ports                                   | direction
//  in      | in_valid/in_ready, start and current xy | word in
//  out     | out_valid/out_ready, end xy, snapped    | word out
//  cfg     | cfg_valid/cfg_ready, cfg_data           | threshold write
//
// One word enters per cycle unless out_ready stalls; the pipeline has 34 square root
// digit stages (which also carry the 20 CORDIC rotations) plus 4 front and 3 back stages.
// Reset clears all valid bits and loads the threshold with 1280.
// A stall on out_ready freezes the whole pipeline; in_ready follows it directly.
module line_angle_snap (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [las_pkg::CW-1:0] in_start_x,
  input  logic signed [las_pkg::CW-1:0] in_start_y,
  input  logic signed [las_pkg::CW-1:0] in_current_x,
  input  logic signed [las_pkg::CW-1:0] in_current_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [las_pkg::CW-1:0] out_end_x,
  output logic signed [las_pkg::CW-1:0] out_end_y,
  output logic                         out_snapped,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [las_pkg::HW-1:0]       cfg_data
);
  import las_pkg::*;

  logic          en;
  logic [HW-1:0] thr_r;
  logic          fv, iv;
  las_ctx_t      fctx, ictx;
  las_work_t     fwk, iwk;

  assign en        = out_ready || !out_valid;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  las_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .start_x   (in_start_x),
    .start_y   (in_start_y),
    .current_x (in_current_x),
    .current_y (in_current_y),
    .out_valid (fv),
    .out_ctx   (fctx),
    .out_work  (fwk)
  );

  las_iter u_iter (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fv),
    .in_ctx    (fctx),
    .in_work   (fwk),
    .out_valid (iv),
    .out_ctx   (ictx),
    .out_work  (iwk)
  );

  las_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .thr       (thr_r),
    .in_valid  (iv),
    .in_ctx    (ictx),
    .in_work   (iwk),
    .out_valid (out_valid),
    .end_x     (out_end_x),
    .end_y     (out_end_y),
    .snapped   (out_snapped)
  );

endmodule
